### rtl/pes_pkg.sv
// Shared types and constants for the PES header parser.
// Word layouts for both channels and the stream class lookup.
// No dependencies.
package pes_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } pes_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic [7:0] stream_code;
    logic       has_optional_header;
    logic       open_length;
    logic       last_payload;
    logic       bad_prefix;
  } pes_out_t;

  localparam int OFFSET_W = 9;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 9'd511;

  localparam logic [OFFSET_W-1:0] OFF_PREFIX0   = 9'd0;
  localparam logic [OFFSET_W-1:0] OFF_PREFIX1   = 9'd1;
  localparam logic [OFFSET_W-1:0] OFF_PREFIX2   = 9'd2;
  localparam logic [OFFSET_W-1:0] OFF_STREAM_ID = 9'd3;
  localparam logic [OFFSET_W-1:0] OFF_LEN_HI    = 9'd4;
  localparam logic [OFFSET_W-1:0] OFF_LEN_LO    = 9'd5;
  // fixed header (6) plus flag bytes (3), minus one: header-length byte
  localparam logic [OFFSET_W-1:0] OFF_HDR_LEN   = 9'd8;
  localparam logic [OFFSET_W:0]   PAYLOAD_BASE  = 10'd9;

  localparam logic [7:0] PREFIX_ZERO = 8'h00;
  localparam logic [7:0] PREFIX_ONE  = 8'h01;

  localparam logic [7:0] SID_PROGRAM_MAP = 8'hbc;
  localparam logic [7:0] SID_PADDING     = 8'hbe;
  localparam logic [7:0] SID_PRIVATE_2   = 8'hbf;
  localparam logic [7:0] SID_ECM         = 8'hf0;
  localparam logic [7:0] SID_EMM         = 8'hf1;
  localparam logic [7:0] SID_DSMCC       = 8'hf2;
  localparam logic [7:0] SID_TYPE_E      = 8'hf8;
  localparam logic [7:0] SID_DIRECTORY   = 8'hff;

  function automatic logic is_special_stream(input logic [7:0] id);
    return (id == SID_PROGRAM_MAP) || (id == SID_PADDING) ||
           (id == SID_PRIVATE_2)   || (id == SID_ECM)     ||
           (id == SID_EMM)         || (id == SID_DSMCC)   ||
           (id == SID_TYPE_E)      || (id == SID_DIRECTORY);
  endfunction

endpackage

### rtl/pes_hdr_parse.sv
// Per-packet parse state and the per-byte classification logic.
// Depends on pes_pkg for word types and stream id constants.
module pes_hdr_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  pes_pkg::pes_in_t item,
  output pes_pkg::pes_out_t result
);
  import pes_pkg::*;

  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [7:0]          sid_r, sid_nxt;
  logic [7:0]          opt_len_r, opt_len_nxt;
  logic [15:0]         remain_r, remain_nxt;
  logic                ordinary_r, ordinary_nxt;
  logic                unbounded_r, unbounded_nxt;
  logic                perr_r, perr_nxt;
  logic                in_pkt_r, in_pkt_nxt;

  logic                payload, last;
  logic                counted;
  logic [15:0]         remain_before;
  logic [7:0]          b;

  always_comb begin
    b = item.data_byte;
    // a packet start wipes the packet state before this byte is parsed
    if (item.packet_start) begin
      in_pkt_nxt    = 1'b1;
      offset_nxt    = '0;
      sid_nxt       = '0;
      opt_len_nxt   = '0;
      remain_nxt    = '0;
      ordinary_nxt  = 1'b0;
      unbounded_nxt = 1'b0;
      perr_nxt      = 1'b0;
    end else begin
      in_pkt_nxt    = in_pkt_r;
      offset_nxt    = offset_r;
      sid_nxt       = sid_r;
      opt_len_nxt   = opt_len_r;
      remain_nxt    = remain_r;
      ordinary_nxt  = ordinary_r;
      unbounded_nxt = unbounded_r;
      perr_nxt      = perr_r;
    end
    payload       = 1'b0;
    last          = 1'b0;
    counted       = 1'b0;
    remain_before = remain_nxt;

    if (in_pkt_nxt) begin
      priority if (offset_nxt == OFF_PREFIX0 || offset_nxt == OFF_PREFIX1) begin
        if (b != PREFIX_ZERO) perr_nxt = 1'b1;
      end else if (offset_nxt == OFF_PREFIX2) begin
        if (b != PREFIX_ONE) perr_nxt = 1'b1;
      end else if (offset_nxt == OFF_STREAM_ID) begin
        sid_nxt      = b;
        ordinary_nxt = !is_special_stream(b);
      end else if (offset_nxt == OFF_LEN_HI) begin
        remain_nxt = {b, 8'h00};
      end else if (offset_nxt == OFF_LEN_LO) begin
        remain_nxt    = {remain_nxt[15:8], b};
        unbounded_nxt = ({remain_nxt[15:8], b} == 16'h0000);
      end else begin
        counted = unbounded_nxt || (remain_nxt != 16'h0000);
        if (ordinary_nxt && offset_nxt == OFF_HDR_LEN) opt_len_nxt = b;
        // count down the declared length, holding at zero
        if (!unbounded_nxt && remain_nxt != 16'h0000) remain_nxt = remain_nxt - 16'd1;
        if (counted) begin
          if (ordinary_nxt) begin
            payload = ({1'b0, offset_nxt} >= (PAYLOAD_BASE + {2'b00, opt_len_nxt}));
          end else begin
            payload = 1'b1;
          end
        end
        last = payload && !unbounded_nxt && (remain_before == 16'd1);
      end
      if (offset_nxt < OFFSET_MAX) offset_nxt = offset_nxt + 9'd1;
    end

    result.out_byte            = b;
    result.is_payload          = payload;
    result.stream_code         = sid_nxt;
    result.has_optional_header = ordinary_nxt;
    result.open_length         = unbounded_nxt;
    result.last_payload        = last;
    result.bad_prefix          = perr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      sid_r       <= '0;
      opt_len_r   <= '0;
      remain_r    <= '0;
      ordinary_r  <= 1'b0;
      unbounded_r <= 1'b0;
      perr_r      <= 1'b0;
      in_pkt_r    <= 1'b0;
    end else if (en) begin
      offset_r    <= offset_nxt;
      sid_r       <= sid_nxt;
      opt_len_r   <= opt_len_nxt;
      remain_r    <= remain_nxt;
      ordinary_r  <= ordinary_nxt;
      unbounded_r <= unbounded_nxt;
      perr_r      <= perr_nxt;
      in_pkt_r    <= in_pkt_nxt;
    end
  end

endmodule

### rtl/pes_header_payload_extractor.sv
// PES header parser top level: one byte word in, one classified word out.
// out_valid rises in the cycle after input accept. Throughput: 1 word per cycle
// while out_stall holds no result; the parse state updates in the accepting cycle
// and the output register refills whenever it is empty or being taken. Synchronous
// active-low reset clears the parse state (no packet seen) and empties the output
// register. Depends on pes_pkg and pes_hdr_parse.
module pes_header_payload_extractor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pes_pkg::pes_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pes_pkg::pes_out_t  out_data
);
  import pes_pkg::*;

  logic     accept;
  pes_out_t result;
  pes_out_t out_data_r;
  logic     out_valid_r;

  // hold input only while a result sits unaccepted downstream
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  pes_hdr_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .item   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
